// ===== src/ltmc_pkg.sv =====
// Shared types and constants for the LRU timestamp model cache.
// No dependencies; used by ltmc_cmp and lru_timestamp_model_cache.
`default_nettype none

package ltmc_pkg;

	localparam int VER_W  = 16;
	localparam int SIZE_W = 16;
	localparam int TIME_W = 31;
	localparam int HIT_W  = 16;
	localparam int SLOT_W = 3;
	localparam int KEYO_W = 8;

	localparam logic [1:0] CMD_ACCESS = 2'd0;
	localparam logic [1:0] CMD_HOT    = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	localparam logic [HIT_W-1:0] HIT_MAX = '1;

	// outcome of one compare step
	typedef struct packed {
		logic match;
		logic older;
	} cmp_res_t;

	// result item, last field listed lands in the lowest bits
	typedef struct packed {
		logic [TIME_W-1:0] slot_time;
		logic [SIZE_W-1:0] slot_size;
		logic [VER_W-1:0]  slot_version;
		logic [KEYO_W-1:0] slot_key;
		logic              slot_valid;
		logic [HIT_W-1:0]  hit_total;
		logic [VER_W-1:0]  old_version;
		logic [VER_W-1:0]  evicted_version;
		logic [KEYO_W-1:0] evicted_key;
		logic              did_evict;
		logic              was_hit;
		logic [SLOT_W-1:0] slot;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

`default_nettype wire

// ===== src/ltmc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ltmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/ltmc_cmp.sv =====
// Shared compare unit of the slot scan: key match and older-time test.
// Depends on ltmc_pkg.
`default_nettype none

module ltmc_cmp #(
	parameter int KEY_BITS = 8
) (
	input  wire logic [KEY_BITS-1:0]       key,
	input  wire logic [KEY_BITS-1:0]       ent_key,
	input  wire logic                      ent_valid,
	input  wire logic [ltmc_pkg::TIME_W-1:0] ent_time,
	input  wire logic                      best_set,
	input  wire logic [ltmc_pkg::TIME_W-1:0] best_time,
	output ltmc_pkg::cmp_res_t             res
);

	// strict less-than keeps the lowest index on equal times
	assign res.match = ent_valid && (ent_key == key);
	assign res.older = !best_set || (ent_time < best_time);

endmodule

`default_nettype wire

// ===== src/lru_timestamp_model_cache.sv =====
// Top level of the LRU timestamp model cache: sequencer, valid bits, entry RAM.
// Depends on ltmc_pkg, ltmc_ram and ltmc_cmp.
//
// Usage
//  Input items arrive on s_axis (tvalid/tready/tdata), one result item per input
//  item leaves on m_axis. Commands 0 and 1 look a key up and update version and
//  time on a hit (command 0 also counts the hit) or fill a slot, command 2 reads
//  a slot, command 3 gives an all-zero result and changes nothing.
//  Lookups scan the entry RAM one slot per cycle through a single compare unit
//  that tracks the first key match, the first free slot and the oldest time.
//  Commands 0 and 1 take one RAM read per slot; then the compare stage is
//  drained, the slot is written and the output register is loaded.
//  An in-range read waits for its RAM read; command 3 or a read beyond
//  ENTRIES sets its result when the item is taken.
//  One item is in work at a time; s_axis_tready is high only while the
//  sequencer is idle, so the next item is taken only once the last result
//  has been loaded into the output register.
//  The result sits in an output register, so the next item is taken while a
//  result still waits; a stalled receiver holds that register and a finished
//  item waits until it is freed.
//  Reset clears all valid bits at once (flip-flops); the RAM contents are only
//  read behind a set valid bit, so no clearing pass is needed.
`default_nettype none

module lru_timestamp_model_cache #(
	parameter int ENTRIES  = 8,
	parameter int KEY_BITS = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// cmd[1:0], model_key[9:2], new_version[25:10], entry_size[41:26],
	// time_stamp[72:42], slot_select[75:73], zero[79:76]
	input  wire logic [79:0]  s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// slot[2:0], was_hit[3], did_evict[4], evicted_key[12:5],
	// evicted_version[28:13], old_version[44:29], hit_total[60:45],
	// slot_valid[61], slot_key[69:62], slot_version[85:70], slot_size[101:86],
	// slot_time[132:102], zero[135:133]
	output logic [135:0]      m_axis_tdata
);

	localparam int IDX_W = $clog2(ENTRIES);

	typedef struct packed {
		logic [KEY_BITS-1:0]              key;
		logic [ltmc_pkg::VER_W-1:0]       ver;
		logic [ltmc_pkg::SIZE_W-1:0]      size;
		logic [ltmc_pkg::TIME_W-1:0]      tm;
		logic [ltmc_pkg::HIT_W-1:0]       hits;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_SETTLE, ST_UPDATE, ST_RD_WAIT, ST_FINISH
	} state_t;

	// input item fields
	logic [1:0]                    in_cmd;
	logic [7:0]                    in_key8;
	logic [ltmc_pkg::VER_W-1:0]    in_ver;
	logic [ltmc_pkg::SIZE_W-1:0]   in_size;
	logic [ltmc_pkg::TIME_W-1:0]   in_time;
	logic [2:0]                    in_sel;
	logic [31:0]                   in_key_ext;
	logic [31:0]                   in_sel_ext;
	logic [IDX_W-1:0]              in_sel_idx;
	logic                          in_sel_ok;

	assign in_cmd     = s_axis_tdata[1:0];
	assign in_key8    = s_axis_tdata[9:2];
	assign in_ver     = s_axis_tdata[25:10];
	assign in_size    = s_axis_tdata[41:26];
	assign in_time    = s_axis_tdata[72:42];
	assign in_sel     = s_axis_tdata[75:73];
	assign in_key_ext = 32'(in_key8);
	assign in_sel_ext = 32'(in_sel);
	assign in_sel_idx = in_sel_ext[IDX_W-1:0];
	assign in_sel_ok  = in_sel_ext < 32'(ENTRIES);

	// control and item registers
	state_t                        state_q;
	logic [ENTRIES-1:0]            valid_q;
	logic [1:0]                    cmd_q;
	logic [KEY_BITS-1:0]           key_q;
	logic [ltmc_pkg::VER_W-1:0]    ver_q;
	logic [ltmc_pkg::SIZE_W-1:0]   size_q;
	logic [ltmc_pkg::TIME_W-1:0]   time_q;
	logic [2:0]                    sel_q;
	logic [IDX_W-1:0]              sel_idx_q;
	logic [IDX_W-1:0]              scan_q;
	logic                          cmp_v_s1;
	logic [IDX_W-1:0]              cmp_idx_s1;

	// scan trackers
	logic                          hit_q;
	logic [IDX_W-1:0]              hit_idx_q;
	ent_t                          hit_ent_q;
	logic                          free_q;
	logic [IDX_W-1:0]              free_idx_q;
	logic                          vic_set_q;
	logic [IDX_W-1:0]              vic_idx_q;
	logic [ltmc_pkg::TIME_W-1:0]   vic_time_q;
	logic [KEY_BITS-1:0]           vic_key_q;
	logic [ltmc_pkg::VER_W-1:0]    vic_ver_q;

	ltmc_pkg::res_t                res_q;
	ltmc_pkg::res_t                out_q;
	logic                          m_tvalid_q;
	logic                          out_load;

	// entry RAM
	logic                          ram_we;
	logic [IDX_W-1:0]              ram_waddr;
	logic [IDX_W-1:0]              ram_raddr;
	logic [ENT_W-1:0]              ram_rdata;
	ent_t                          rd_ent;
	ent_t                          upd_ent;
	logic [IDX_W-1:0]              upd_idx;

	assign rd_ent    = ent_t'(ram_rdata);
	assign ram_raddr = (state_q == ST_IDLE) ? in_sel_idx : scan_q;
	assign ram_we    = (state_q == ST_UPDATE);
	assign ram_waddr = upd_idx;

	ltmc_ram #(
		.WIDTH (ENT_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (upd_ent),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ltmc_pkg::cmp_res_t cmp_res;

	ltmc_cmp #(
		.KEY_BITS (KEY_BITS)
	) u_cmp (
		.key       (key_q),
		.ent_key   (rd_ent.key),
		.ent_valid (valid_q[cmp_idx_s1]),
		.ent_time  (rd_ent.tm),
		.best_set  (vic_set_q),
		.best_time (vic_time_q),
		.res       (cmp_res)
	);

	// slot update after the scan
	logic [31:0]                   upd_idx_ext;
	logic [31:0]                   key_q_ext;
	logic [31:0]                   vic_key_ext;
	logic [31:0]                   rd_key_ext;
	logic                          evict;
	logic [ltmc_pkg::HIT_W-1:0]    hit_inc;
	ltmc_pkg::res_t                upd_res;
	ltmc_pkg::res_t                rd_res;
	ltmc_pkg::res_t                acc_res;

	assign evict   = !hit_q && !free_q;
	assign upd_idx = hit_q ? hit_idx_q : (free_q ? free_idx_q : vic_idx_q);
	assign hit_inc = (hit_ent_q.hits == ltmc_pkg::HIT_MAX) ? hit_ent_q.hits
	                 : hit_ent_q.hits + 1'b1;

	always_comb begin
		upd_ent.key  = key_q;
		upd_ent.ver  = ver_q;
		upd_ent.size = hit_q ? hit_ent_q.size : size_q;
		upd_ent.tm   = time_q;
		if (!hit_q) begin
			upd_ent.hits = ltmc_pkg::HIT_W'(1);
		end else if (cmd_q == ltmc_pkg::CMD_ACCESS) begin
			upd_ent.hits = hit_inc;
		end else begin
			upd_ent.hits = hit_ent_q.hits;
		end
	end

	assign upd_idx_ext = 32'(upd_idx);
	assign key_q_ext   = 32'(key_q);
	assign vic_key_ext = 32'(vic_key_q);
	assign rd_key_ext  = 32'(rd_ent.key);

	always_comb begin
		upd_res                 = '0;
		upd_res.slot            = upd_idx_ext[2:0];
		upd_res.was_hit         = hit_q;
		upd_res.did_evict       = evict;
		upd_res.evicted_key     = evict ? vic_key_ext[7:0] : '0;
		upd_res.evicted_version = evict ? vic_ver_q : '0;
		upd_res.old_version     = (hit_q && cmd_q == ltmc_pkg::CMD_HOT)
		                          ? hit_ent_q.ver : '0;
		upd_res.hit_total       = upd_ent.hits;
		upd_res.slot_valid      = 1'b1;
		upd_res.slot_key        = key_q_ext[7:0];
		upd_res.slot_version    = ver_q;
		upd_res.slot_size       = upd_ent.size;
		upd_res.slot_time       = time_q;
	end

	always_comb begin
		rd_res      = '0;
		rd_res.slot = sel_q;
		if (valid_q[sel_idx_q]) begin
			rd_res.hit_total    = rd_ent.hits;
			rd_res.slot_valid   = 1'b1;
			rd_res.slot_key     = rd_key_ext[7:0];
			rd_res.slot_version = rd_ent.ver;
			rd_res.slot_size    = rd_ent.size;
			rd_res.slot_time    = rd_ent.tm;
		end
	end

	// immediate result: unused command or read beyond the table
	always_comb begin
		acc_res      = '0;
		acc_res.slot = (in_cmd == ltmc_pkg::CMD_READ) ? in_sel : 3'd0;
	end

	// output register takes a finished item when empty or being emptied
	assign out_load = (state_q == ST_FINISH) && (!m_tvalid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			cmd_q      <= ltmc_pkg::CMD_ACCESS;
			key_q      <= '0;
			ver_q      <= '0;
			size_q     <= '0;
			time_q     <= '0;
			sel_q      <= '0;
			sel_idx_q  <= '0;
			scan_q     <= '0;
			cmp_v_s1   <= 1'b0;
			cmp_idx_s1 <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			hit_ent_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			vic_set_q  <= 1'b0;
			vic_idx_q  <= '0;
			vic_time_q <= '0;
			vic_key_q  <= '0;
			vic_ver_q  <= '0;
			res_q      <= '0;
			out_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			cmp_v_s1   <= (state_q == ST_SCAN);
			cmp_idx_s1 <= scan_q;

			if (out_load) begin
				out_q      <= res_q;
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end

			// compare stage: one slot per cycle through the shared unit
			if (cmp_v_s1) begin
				if (cmp_res.match && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= cmp_idx_s1;
					hit_ent_q <= rd_ent;
				end
				if (!valid_q[cmp_idx_s1] && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= cmp_idx_s1;
				end
				if (cmp_res.older) begin
					vic_set_q  <= 1'b1;
					vic_idx_q  <= cmp_idx_s1;
					vic_time_q <= rd_ent.tm;
					vic_key_q  <= rd_ent.key;
					vic_ver_q  <= rd_ent.ver;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q     <= in_cmd;
						key_q     <= in_key_ext[KEY_BITS-1:0];
						ver_q     <= in_ver;
						size_q    <= in_size;
						time_q    <= in_time;
						sel_q     <= in_sel;
						sel_idx_q <= in_sel_idx;
						scan_q    <= '0;
						hit_q     <= 1'b0;
						free_q    <= 1'b0;
						vic_set_q <= 1'b0;
						if (in_cmd == ltmc_pkg::CMD_ACCESS || in_cmd == ltmc_pkg::CMD_HOT) begin
							state_q <= ST_SCAN;
						end else if (in_cmd == ltmc_pkg::CMD_READ && in_sel_ok) begin
							state_q <= ST_RD_WAIT;
						end else begin
							res_q   <= acc_res;
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					if (scan_q == IDX_W'(ENTRIES - 1)) begin
						state_q <= ST_SETTLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_SETTLE: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					valid_q[upd_idx] <= 1'b1;
					res_q            <= upd_res;
					state_q          <= ST_FINISH;
				end
				ST_RD_WAIT: begin
					res_q   <= rd_res;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {3'b000, out_q};

	// a hit always refers to a slot that is valid
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && hit_q) |-> valid_q[hit_idx_q])
		else $error("hit on an invalid slot");

	// eviction only when every slot is taken
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && !hit_q && !free_q) |-> (&valid_q))
		else $error("eviction with a free slot");

	// the updated slot is valid afterwards
	a_upd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |=> valid_q[$past(upd_idx)])
		else $error("updated slot not marked valid");

	// a new result appears only out of the finish step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish step");

endmodule

`default_nettype wire
